FILE: design/mono_bitmap_blit_clip_defines.svh
// Assertion macros shared by the bitmap blit checker.
`ifndef MONO_BITMAP_BLIT_CLIP_DEFINES_SVH
`define MONO_BITMAP_BLIT_CLIP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbb checker: property violated");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbb checker: property violated");

`endif

FILE: design/mbb_pkg.sv
// Types and constants shared by the bitmap blit modules.
package mbb_pkg;

    // Widest store address over the supported display sizes (256 bytes x 2048 rows).
    localparam int STORE_ADDR_W = 19;

    // Transaction opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SOURCE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_WRITE  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEST_X       = 2'd0;
    localparam logic [1:0] CFG_DEST_Y       = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // Store jobs handed from the front to the back
    localparam logic [1:0] JOB_NONE  = 2'd0;
    localparam logic [1:0] JOB_READ  = 2'd1;
    localparam logic [1:0] JOB_WRITE = 2'd2;
    localparam logic [1:0] JOB_BLIT  = 2'd3;

    // Pixel mask of a source byte before alignment: leftmost eight pixels.
    localparam logic [15:0] LEAD_MASK  = 16'hFF00;
    localparam logic [7:0]  WHITE_BYTE = 8'hFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data;
        logic [15:0] address;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       any_pixel_drawn;
        logic       image_done;
    } out_item_t;

    // One classified transaction; pixels/mask span the first store byte
    // (upper half) and the byte after it (lower half).
    typedef struct packed {
        logic [1:0]              job;
        logic [STORE_ADDR_W-1:0] addr;
        logic [15:0]             pixels;
        logic [15:0]             mask;
        logic                    drawn;
        logic                    done;
    } job_t;

endpackage

FILE: design/mbb_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface mbb_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/mbb_front.sv
// Front end: configuration registers, source counters and transaction classification.
module mbb_front #(
    parameter int DISP_WIDTH  = 792,
    parameter int DISP_HEIGHT = 528
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data,
    mbb_stream_if.sink          in_ch,
    input  logic                accept_en,
    output logic                push,
    output mbb_pkg::job_t       job
);
    localparam int ROW_BYTES   = (DISP_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * DISP_HEIGHT;
    localparam int AW          = mbb_pkg::STORE_ADDR_W;
    localparam logic [11:0] WIDTH_C  = 12'(DISP_WIDTH);
    localparam logic [11:0] HEIGHT_C = 12'(DISP_HEIGHT);

    logic [9:0] dest_x_reg, dest_y_reg, image_width_reg, image_height_reg;
    logic [9:0] row_reg, row_next;
    logic [6:0] col_reg, col_next;

    mbb_pkg::in_item_t item;
    logic [7:0]  row_bytes;
    logic [7:0]  col_inc;
    logic        wrap;
    logic        active;
    logic [9:0]  row_after;
    logic [10:0] py, px0;
    logic        py_ok, px_ok, addr_ok;
    logic [7:0]  byte_col;
    logic [2:0]  shift;
    logic [AW-1:0] row_base, blit_addr;
    logic [11:0] span;
    logic [15:0] edge_mask;

    assign item      = in_ch.payload;
    assign in_ch.ready = accept_en;
    assign push      = in_ch.valid && accept_en;

    assign row_bytes = 8'((11'(image_width_reg) + 11'd7) >> 3);
    assign col_inc   = {1'b0, col_reg} + 8'd1;
    assign wrap      = (col_inc >= row_bytes);
    assign active    = (row_bytes != 8'd0) && (row_reg < image_height_reg);
    assign row_after = wrap ? row_reg + 10'd1 : row_reg;

    assign py    = 11'(dest_y_reg) + 11'(row_reg);
    assign px0   = 11'(dest_x_reg) + 11'({col_reg, 3'b000});
    assign py_ok = ({1'b0, py} < HEIGHT_C);
    assign px_ok = ({1'b0, px0} < WIDTH_C);
    assign byte_col = px0[10:3];
    assign shift    = px0[2:0];

    assign row_base  = AW'(py) * AW'(ROW_BYTES);
    assign blit_addr = row_base + AW'(byte_col);
    assign span      = WIDTH_C - {1'b0, byte_col, 3'b000};
    assign addr_ok   = ({16'h0000, item.address} < 32'(STORE_BYTES));

    // clip pixels at or past the display's right edge
    always_comb
    begin
        for (int j = 0; j < 16; j++)
        begin
            edge_mask[15 - j] = (12'(j) < span);
        end
    end

    always_comb
    begin
        job        = '0;
        job.job    = mbb_pkg::JOB_NONE;
        job.addr   = AW'(item.address);
        job.pixels = {item.data, 8'h00};
        job.mask   = '0;
        case (item.opcode)
            mbb_pkg::OP_START:
            begin
                job.job = mbb_pkg::JOB_NONE;
            end
            mbb_pkg::OP_SOURCE:
            begin
                job.done = active && (row_after == image_height_reg);
                if (active && py_ok && px_ok)
                begin
                    job.job    = mbb_pkg::JOB_BLIT;
                    job.addr   = blit_addr;
                    job.pixels = {item.data, 8'h00} >> shift;
                    job.mask   = (mbb_pkg::LEAD_MASK >> shift) & edge_mask;
                    job.drawn  = 1'b1;
                end
            end
            mbb_pkg::OP_READ:
            begin
                if (addr_ok)
                    job.job = mbb_pkg::JOB_READ;
            end
            mbb_pkg::OP_WRITE:
            begin
                if (addr_ok)
                    job.job = mbb_pkg::JOB_WRITE;
            end
            default:
            begin
                job.job = mbb_pkg::JOB_NONE;
            end
        endcase
    end

    // advance the source counters
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (push)
        begin
            if (item.opcode == mbb_pkg::OP_START)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (item.opcode == mbb_pkg::OP_SOURCE && active)
            begin
                row_next = row_after;
                col_next = wrap ? 7'd0 : col_inc[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg       <= '0;
            dest_y_reg       <= '0;
            image_width_reg  <= '0;
            image_height_reg <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    mbb_pkg::CFG_DEST_X:       dest_x_reg       <= cfg_data;
                    mbb_pkg::CFG_DEST_Y:       dest_y_reg       <= cfg_data;
                    mbb_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                    mbb_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                    default:                   dest_x_reg       <= dest_x_reg;
                endcase
            end
        end
    end
endmodule

FILE: design/mbb_queue.sv
// Two-entry job queue between the front end and the store sequencer.
module mbb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          filled,
    output mbb_pkg::job_t head
);
    mbb_pkg::job_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign filled = (count_reg != 2'd0);
    assign head   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end
endmodule

FILE: design/mbb_back.sv
// Back end: frame store, clearing pass and read-modify-write sequencer.
module mbb_back #(
    parameter int DISP_WIDTH  = 792,
    parameter int DISP_HEIGHT = 528
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          filled,
    input  mbb_pkg::job_t head,
    output logic          pop,
    output logic          clearing,
    mbb_stream_if.source  out_ch
);
    localparam int STORE_BYTES = ((DISP_WIDTH + 7) / 8) * DISP_HEIGHT;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int AW          = mbb_pkg::STORE_ADDR_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_READ    = 3'd2;
    localparam logic [2:0] ST_MERGE_A = 3'd3;
    localparam logic [2:0] ST_FETCH_B = 3'd4;
    localparam logic [2:0] ST_MERGE_B = 3'd5;

    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    mbb_pkg::job_t     work_reg, work_next;
    logic              out_valid_reg, out_valid_next;
    mbb_pkg::out_item_t out_item_reg, out_item_next;

    logic              slot_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [AW-1:0]     addr_b;

    assign slot_free      = !out_valid_reg || out_ch.ready;
    assign clearing       = (state_reg == ST_CLEAR);
    assign addr_b         = work_reg.addr + AW'(1);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        work_next       = work_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_item_next   = out_item_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = ADDR_W'(head.addr);
        mem_wdata       = head.pixels[15:8];
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clear_addr_reg;
                mem_wdata = mbb_pkg::WHITE_BYTE;
                if (clear_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
                else
                    clear_addr_next = clear_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (filled && slot_free)
                begin
                    pop       = 1'b1;
                    work_next = head;
                    case (head.job)
                        mbb_pkg::JOB_READ:  state_next = ST_READ;
                        mbb_pkg::JOB_BLIT:  state_next = ST_MERGE_A;
                        mbb_pkg::JOB_WRITE:
                        begin
                            mem_we         = 1'b1;
                            out_valid_next = 1'b1;
                            out_item_next  = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '{read_data: 8'h00,
                                               any_pixel_drawn: head.drawn,
                                               image_done: head.done};
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_item_next  = '{read_data: rdata_reg, any_pixel_drawn: 1'b0,
                                   image_done: 1'b0};
                state_next     = ST_IDLE;
            end
            ST_MERGE_A:
            begin
                mem_we    = 1'b1;
                mem_addr  = ADDR_W'(work_reg.addr);
                mem_wdata = (rdata_reg & ~work_reg.mask[15:8])
                          | (work_reg.pixels[15:8] & work_reg.mask[15:8]);
                if (work_reg.mask[7:0] != 8'h00)
                    state_next = ST_FETCH_B;
                else
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{read_data: 8'h00, any_pixel_drawn: work_reg.drawn,
                                       image_done: work_reg.done};
                    state_next     = ST_IDLE;
                end
            end
            ST_FETCH_B:
            begin
                mem_addr   = ADDR_W'(addr_b);
                state_next = ST_MERGE_B;
            end
            ST_MERGE_B:
            begin
                mem_we    = 1'b1;
                mem_addr  = ADDR_W'(addr_b);
                mem_wdata = (rdata_reg & ~work_reg.mask[7:0])
                          | (work_reg.pixels[7:0] & work_reg.mask[7:0]);
                out_valid_next = 1'b1;
                out_item_next  = '{read_data: 8'h00, any_pixel_drawn: work_reg.drawn,
                                   image_done: work_reg.done};
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // single-port store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_addr] <= mem_wdata;
        else
            rdata_reg <= store_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end
endmodule

FILE: design/mono_bitmap_blit_clip.sv
// Path: a result passes through the job queue and the output register; a store read or a
// blit byte also passes the registered store read, and a byte that spans two store bytes
// runs a second read and merge. Throughput: one transaction a cycle without store access
// while the output is free; the single store port and its read-modify-write slow the rest.
// Reset: counters and registers clear at once; then a clearing pass writes every store
// byte white, (DISP_WIDTH+7)/8*DISP_HEIGHT bytes (52272 by default), with input held off.
module mono_bitmap_blit_clip #(
    parameter int DISP_WIDTH  = 792,
    parameter int DISP_HEIGHT = 528
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [1:0]   cfg_index,
    input  logic [9:0]   cfg_data,
    mbb_stream_if.sink   in_ch,
    mbb_stream_if.source out_ch
);
    // Front -> queue: classified jobs with precomputed store address, aligned
    // pixels and clip mask. The source counters live in the front, so blit
    // order is fixed there and the back only replays store accesses in order.
    logic          push;
    mbb_pkg::job_t push_job;
    logic          q_full;

    // Queue -> back
    logic          q_filled;
    logic          pop;
    mbb_pkg::job_t head;

    // Hold off input while the queue is full or the store is still clearing.
    logic clearing;
    logic accept_en;

    assign accept_en = !q_full && !clearing;

    mbb_front #(
        .DISP_WIDTH (DISP_WIDTH),
        .DISP_HEIGHT(DISP_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .accept_en(accept_en),
        .push     (push),
        .job      (push_job)
    );

    // Two entries let the front keep taking transactions while the back
    // works through a read-modify-write or waits on a stalled result.
    mbb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .full    (q_full),
        .pop     (pop),
        .filled  (q_filled),
        .head    (head)
    );

    // The back owns the store and the output register; it drops a result
    // into the register only when the register is free or being drained.
    mbb_back #(
        .DISP_WIDTH (DISP_WIDTH),
        .DISP_HEIGHT(DISP_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .filled  (q_filled),
        .head    (head),
        .pop     (pop),
        .clearing(clearing),
        .out_ch  (out_ch)
    );
endmodule

FILE: design/mbb_checker.sv
// Port-level checker for the bitmap blit, attached to the top level by bind.
`include "mono_bitmap_blit_clip_defines.svh"

module mbb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input mbb_pkg::out_item_t out_item
);
    logic blit_flag;

    assign blit_flag = out_item.any_pixel_drawn || out_item.image_done;

    // a stalled result holds
    `MBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    // blit results never carry store data
    `MBB_ASSERT_SAME(a_blit_no_data, out_valid && blit_flag, out_item.read_data == 8'h00)
    // the clearing pass keeps input off right after reset
    `MBB_ASSERT_SAME(a_clear_first, $rose(rst_n), !in_ready)
    // nothing comes out or is taken in during the first cycle after reset
    `MBB_ASSERT_SAME(a_quiet_start, $rose(rst_n), !out_valid && !(in_valid && in_ready))
endmodule

bind mono_bitmap_blit_clip mbb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_item (out_ch.payload)
);

FILE: sim/mono_bitmap_blit_clip_tb.sv
// Self-checking testbench for the one-bit-per-pixel bitmap blit with clipping.
module mono_bitmap_blit_clip_tb;

    localparam int DISP_WIDTH    = 792;
    localparam int DISP_HEIGHT   = 528;
    localparam int ROW_BYTES     = (DISP_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = ROW_BYTES * DISP_HEIGHT;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;     // long sink back-pressure stretch
    // Covers the clearing pass plus every transaction at worst stalls.
    localparam int CYCLE_LIMIT   = 600000;

    // Idle percentages per phase: none, sender only, receiver only, both.
    localparam int SRC_IDLE [4] = '{0, 69, 0, 12};
    localparam int SNK_IDLE [4] = '{0, 0, 69, 12};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [9:0] cfg_data;

    mbb_stream_if #(.payload_t(mbb_pkg::in_item_t))  in_ch ();
    mbb_stream_if #(.payload_t(mbb_pkg::out_item_t)) out_ch ();

    mono_bitmap_blit_clip #(
        .DISP_WIDTH  (DISP_WIDTH),
        .DISP_HEIGHT (DISP_HEIGHT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #1 clk = ~clk;

    // Mirror of the block: packed frame store, source counters and registers.
    logic [7:0] frame_model [STORE_BYTES];
    logic [9:0] src_row;
    logic [6:0] src_col;
    logic [9:0] dest_x;
    logic [9:0] dest_y;
    logic [9:0] img_w;
    logic [9:0] img_h;

    mbb_pkg::in_item_t  items_to_send [$];   // filled by the sequence, drained by the driver
    mbb_pkg::out_item_t results_due [$];     // predicted results, oldest first
    mbb_pkg::out_item_t want;

    int pushed_count   = 0;
    int accepted_count = 0;
    int random_items   = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int src_idle_pct   = 0;
    int snk_idle_pct   = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    // Paint one source byte at the current counters; clip right and bottom.
    // Returns 1 when at least one pixel landed inside the display.
    function automatic bit paint_byte(logic [7:0] src);
        int unsigned py;
        int unsigned px0;
        int unsigned px;
        int unsigned idx;
        logic [7:0]  mask;
        bit          drawn;
        drawn = 1'b0;
        py  = int'(dest_y) + int'(src_row);
        px0 = int'(dest_x) + int'(src_col) * 8;
        if (py >= DISP_HEIGHT)
            return 1'b0;
        for (int b = 0; b < 8; b++)
        begin
            px = px0 + b;
            if (px >= DISP_WIDTH)
                break;
            idx  = py * ROW_BYTES + px / 8;
            mask = 8'h80 >> (px % 8);
            if (src[7 - b])
                frame_model[idx] = frame_model[idx] | mask;
            else
                frame_model[idx] = frame_model[idx] & ~mask;
            drawn = 1'b1;
        end
        return drawn;
    endfunction

    // Advance the mirror by one accepted transaction and return its result.
    function automatic mbb_pkg::out_item_t blit_step(mbb_pkg::in_item_t it);
        mbb_pkg::out_item_t res;
        int unsigned        row_bytes;
        res = '0;
        case (it.opcode)
            mbb_pkg::OP_START:
            begin
                src_row = '0;
                src_col = '0;
            end
            mbb_pkg::OP_SOURCE:
            begin
                row_bytes = (int'(img_w) + 7) >> 3;
                // Zero width or rows exhausted: the byte is ignored.
                if (row_bytes != 0 && src_row < img_h)
                begin
                    res.any_pixel_drawn = paint_byte(it.data);
                    // A column past a shrunk row width still wraps to the next row.
                    if (int'(src_col) + 1 >= row_bytes)
                    begin
                        src_col = '0;
                        src_row = src_row + 10'd1;
                    end
                    else
                    begin
                        src_col = src_col + 7'd1;
                    end
                    res.image_done = (src_row == img_h);
                end
            end
            mbb_pkg::OP_READ:
            begin
                if (it.address < STORE_BYTES)
                    res.read_data = frame_model[it.address];
            end
            default:
            begin
                if (it.address < STORE_BYTES)
                    frame_model[it.address] = it.data;
            end
        endcase
        return res;
    endfunction

    function automatic void push_item(logic [1:0] op, logic [7:0] d, logic [15:0] a);
        mbb_pkg::in_item_t it;
        it.opcode  = op;
        it.data    = d;
        it.address = a;
        items_to_send.push_back(it);
        pushed_count++;
    endfunction

    // Hold until every queued transaction has been taken and answered, then let
    // the pipeline settle.
    task automatic wait_drained();
        while (accepted_count != pushed_count || results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [9:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            mbb_pkg::CFG_DEST_X:      dest_x = val;
            mbb_pkg::CFG_DEST_Y:      dest_y = val;
            mbb_pkg::CFG_IMAGE_WIDTH: img_w  = val;
            default:                  img_h  = val;
        endcase
    endtask

    // Program all four registers; only done with the block idle.
    task automatic configure(int dx, int dy, int w, int h);
        wait_drained();
        write_reg(mbb_pkg::CFG_DEST_X, 10'(dx));
        write_reg(mbb_pkg::CFG_DEST_Y, 10'(dy));
        write_reg(mbb_pkg::CFG_IMAGE_WIDTH, 10'(w));
        write_reg(mbb_pkg::CFG_IMAGE_HEIGHT, 10'(h));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // One random blit: placement, optional pre-painted background, a start and
    // the image bytes with occasional noise, up to two bytes past the end, then a
    // read-back of the painted area after the results have all come back.
    task automatic blit_round(int round_no);
        int dx;
        int dy;
        int w;
        int h;
        int rb;
        int nbytes;
        int trailing;
        int mark;
        int first_byte;
        int last_byte;
        dx = $urandom_range(780);
        dy = $urandom_range(524);
        w  = $urandom_range(1, 40);
        h  = $urandom_range(1, 5);
        case ($urandom_range(7))
            0:
            begin
                dx = $urandom_range(1023);
                dy = $urandom_range(1023);
            end
            1:
            begin
                dx = $urandom_range(760, 791);
                dy = $urandom_range(520, 527);
            end
            2:       w = 0;
            default: ;
        endcase
        // Widest row (128 bytes) and tallest image get a round each.
        if (round_no == 0)
        begin
            w = 1023;
            h = 1;
        end
        if (round_no == 1)
        begin
            w = 8;
            h = 1023;
        end
        // Enough bytes behind the long hold-off to back the block up.
        if (round_no == 4)
        begin
            w = 40;
            h = 5;
        end
        configure(dx, dy, w, h);
        src_idle_pct = SRC_IDLE[round_no % 4];
        snk_idle_pct = SNK_IDLE[round_no % 4];
        rb   = (w + 7) / 8;
        mark = pushed_count;

        // Random background under the first row so unpainted bits are checked.
        if ($urandom_range(9) < 3 && dy < DISP_HEIGHT)
            for (int i = 0; i < 3; i++)
                if (dx / 8 + i < ROW_BYTES)
                    push_item(mbb_pkg::OP_WRITE, 8'($urandom_range(255)),
                              16'(dy * ROW_BYTES + dx / 8 + i));

        // Stall the receiver for a long stretch so the block backs up its input.
        if (round_no == 4)
            hold_requests++;

        push_item(mbb_pkg::OP_START, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        nbytes = rb * h;
        if (nbytes > 130)
            nbytes = $urandom_range(4, 12);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(9) == 0)
                push_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          16'($urandom_range(65535)));
            push_item(mbb_pkg::OP_SOURCE, 8'($urandom_range(255)),
                      16'($urandom_range(65535)));
        end
        trailing = $urandom_range(2);
        repeat (trailing)
            push_item(mbb_pkg::OP_SOURCE, 8'($urandom_range(255)),
                      16'($urandom_range(65535)));

        // Pause the sender until every result is in, then read back.
        wait_drained();
        if (rb != 0)
        begin
            first_byte = dx / 8;
            last_byte  = (dx + rb * 8 - 1) / 8;
            if (last_byte > ROW_BYTES - 1)
                last_byte = ROW_BYTES - 1;
            if (last_byte > first_byte + 16)
                last_byte = first_byte + 16;
            for (int r = 0; r < h && r < 3; r++)
                if (dy + r < DISP_HEIGHT)
                    for (int c = first_byte; c <= last_byte; c++)
                        push_item(mbb_pkg::OP_READ, 8'h00, 16'((dy + r) * ROW_BYTES + c));
        end
        random_items += pushed_count - mark - trailing;
    endtask

    // Driver: predict each accepted transaction, then offer the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                results_due.push_back(blit_step(in_ch.payload));
                accepted_count++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_ch.payload <= items_to_send.pop_front();
                    in_ch.valid   <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction and drive ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: read_data %0h drawn %0b done %0b",
                           out_ch.payload.read_data, out_ch.payload.any_pixel_drawn,
                           out_ch.payload.image_done);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (out_ch.payload.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, out_ch.payload.read_data);
                        error_count++;
                    end
                    if (out_ch.payload.any_pixel_drawn !== want.any_pixel_drawn)
                    begin
                        $error("any_pixel_drawn: expected %0b, got %0b",
                               want.any_pixel_drawn, out_ch.payload.any_pixel_drawn);
                        error_count++;
                    end
                    if (out_ch.payload.image_done !== want.image_done)
                    begin
                        $error("image_done: expected %0b, got %0b",
                               want.image_done, out_ch.payload.image_done);
                        error_count++;
                    end
                end
            end
            // Count a requested hold-off here, independent of the sequence.
            if (hold_requests != holds_served)
            begin
                hold_left = HOLD_CYCLES;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        // Known values on every input before the first edge.
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = mbb_pkg::CFG_DEST_X;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++)
            frame_model[i] = mbb_pkg::WHITE_BYTE;
        src_row = '0;
        src_col = '0;
        dest_x  = '0;
        dest_y  = '0;
        img_w   = '0;
        img_h   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset: zero width drops source bytes. Store edges and
        // out-of-range addresses (read gives zero, write is dropped).
        push_item(mbb_pkg::OP_SOURCE, 8'h5A, 16'h0000);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'd0);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'(STORE_BYTES));
        push_item(mbb_pkg::OP_WRITE,  8'h00, 16'hFFFF);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'hFFFF);
        push_item(mbb_pkg::OP_WRITE,  8'h00, 16'(STORE_BYTES - 1));
        push_item(mbb_pkg::OP_READ,   8'h00, 16'(STORE_BYTES - 1));

        // No start since reset: counters act as a fresh blit. Unaligned x,
        // padding bits drawn, last byte flags done, the byte after is ignored.
        configure(3, 0, 12, 2);
        push_item(mbb_pkg::OP_SOURCE, 8'hA5, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h0F, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'hFF, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h00, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h55, 16'h0000);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'd1);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'(ROW_BYTES + 1));

        // Right and bottom clipping: partial byte, byte fully off, row off.
        configure(788, 527, 16, 2);
        push_item(mbb_pkg::OP_START,  8'h00, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'hF0, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h0F, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'hFF, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h00, 16'h0000);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'(STORE_BYTES - 1));

        // Placement at the register maximum: everything falls off the display.
        configure(1023, 1023, 24, 2);
        push_item(mbb_pkg::OP_START,  8'hFF, 16'hFFFF);
        push_item(mbb_pkg::OP_SOURCE, 8'h00, 16'h0000);

        // Width shrinks mid-blit: the column past the new row width draws,
        // then wraps to the next row.
        configure(16, 10, 24, 2);
        push_item(mbb_pkg::OP_START,  8'h00, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h3C, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'hC3, 16'h0000);
        configure(16, 10, 8, 2);
        push_item(mbb_pkg::OP_SOURCE, 8'h00, 16'h0000);
        push_item(mbb_pkg::OP_SOURCE, 8'h81, 16'h0000);
        push_item(mbb_pkg::OP_READ,   8'h00, 16'(10 * ROW_BYTES + 4));
        push_item(mbb_pkg::OP_READ,   8'h00, 16'(11 * ROW_BYTES + 2));

        // Random blits until enough transactions have gone through.
        for (int round_no = 0; random_items < RANDOM_ITEMS; round_no++)
            blit_round(round_no);

        wait_drained();
        if (error_count == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
